// ----- rtl/asert_pkg.sv -----
`timescale 1ns / 1ps

package asert_pkg;

	// quotient bits kept by the exponent divider
	localparam int QBITS = 25;

	// result classification
	localparam logic [1:0] KIND_COMPUTED = 2'd0;
	localparam logic [1:0] KIND_ONE      = 2'd1;
	localparam logic [1:0] KIND_LIMIT    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_POW_W0       = 3'd0;
	localparam logic [2:0] REG_POW_W1       = 3'd1;
	localparam logic [2:0] REG_POW_W2       = 3'd2;
	localparam logic [2:0] REG_POW_W3       = 3'd3;
	localparam logic [2:0] REG_HALF_LIFE    = 3'd4;
	localparam logic [2:0] REG_SPACING      = 3'd5;
	localparam logic [2:0] REG_ANCHOR_TIME  = 3'd6;
	localparam logic [2:0] REG_ANCHOR_BITS  = 3'd7;

	// cubic approximation of 2^x in 48-bit fixed point
	localparam logic [47:0] POLY_A     = 48'd195766423245049;
	localparam logic [29:0] POLY_B     = 30'd971821376;
	localparam logic [12:0] POLY_C     = 13'd5127;
	localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;
	localparam logic [16:0] FACTOR_ONE = 17'd65536;

	localparam logic signed [9:0] SHIFT_MIN = -10'sd256;
	localparam logic signed [9:0] SHIFT_MAX = 10'sd15;

	localparam logic [255:0] TARGET_ONE = 256'd1;

	typedef struct packed {
		logic [23:0] prev_height;
		logic [31:0] prev_time;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_bits;
		logic [1:0]  clamp_kind;
	} result_t;

	typedef struct packed {
		logic [255:0] limit_target;
		logic [30:0]  half_life;
		logic [15:0]  target_spacing;
		logic [31:0]  anchor_time;
		logic [31:0]  anchor_bits;
	} cfg_t;

	// divider result: overflow flag, sign and magnitude of the truncated exponent
	typedef struct packed {
		logic             big;
		logic             neg;
		logic [QBITS-1:0] mag;
	} expo_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic signed [9:0] shifts;
		logic [16:0]       factor;
	} factor_t;

	typedef struct packed {
		logic [1:0]   kind;
		logic [255:0] value;
	} target_t;

endpackage

// ----- rtl/asert_next_target.sv -----
`timescale 1ns / 1ps

// asert next-target engine
// item channel: item_valid / item_stall carry the previous block height and
//   timestamp; an item is taken on a clock edge with item_valid high and
//   item_stall low
// result channel: result_valid / result_stall carry the compact target for
//   the next block and a clamp code (computed, forced to one, forced to limit)
// cfg port: cfg_we writes cfg_data into register cfg_index on the clock edge;
//   registers are easiest-target words 0..3, half life, spacing, anchor time
//   and anchor bits; write only while no item is in flight
// pipeline: 41 stages; one item per cycle sustained while the result side
//   does not stall
//   the exponent divider has 4 setup stages followed by one stage per
//   quotient bit (25 stages), then come 5 polynomial stages, 4 scaling
//   stages and 3 compact-encoding stages
// every stage holds its own valid bit, so a stall on the result side only
//   freezes stages that are occupied; bubbles keep collapsing and new items
//   are taken as long as the first stage can move
// reset clears all valid bits and loads the default chain parameters

module asert_next_target (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  asert_pkg::in_item_t item,
	output logic                result_valid,
	input  logic                result_stall,
	output asert_pkg::result_t  result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	// configuration registers
	logic [63:0] pow_w0_q, pow_w1_q, pow_w2_q, pow_w3_q;
	logic [30:0] half_life_q;
	logic [15:0] spacing_q;
	logic [31:0] anchor_time_q;
	logic [31:0] anchor_bits_q;

	asert_pkg::cfg_t cfg;

	// inter-unit channels
	logic               expo_valid, expo_stall;
	asert_pkg::expo_t   expo;
	logic               factor_valid, factor_stall;
	asert_pkg::factor_t factor;
	logic               target_valid, target_stall;
	asert_pkg::target_t target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_w0_q      <= 64'hFFFF_FFFF_FFFF_FFFF;
			pow_w1_q      <= 64'hFFFF_FFFF_FFFF_FFFF;
			pow_w2_q      <= 64'hFFFF_FFFF_FFFF_FFFF;
			pow_w3_q      <= 64'h0000_0000_FFFF_FFFF;
			half_life_q   <= 31'd172800;
			spacing_q     <= 16'd600;
			anchor_time_q <= 32'd0;
			anchor_bits_q <= 32'h1D00_FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				asert_pkg::REG_POW_W0:      pow_w0_q      <= cfg_data;
				asert_pkg::REG_POW_W1:      pow_w1_q      <= cfg_data;
				asert_pkg::REG_POW_W2:      pow_w2_q      <= cfg_data;
				asert_pkg::REG_POW_W3:      pow_w3_q      <= cfg_data;
				asert_pkg::REG_HALF_LIFE:   half_life_q   <= cfg_data[30:0];
				asert_pkg::REG_SPACING:     spacing_q     <= cfg_data[15:0];
				asert_pkg::REG_ANCHOR_TIME: anchor_time_q <= cfg_data[31:0];
				asert_pkg::REG_ANCHOR_BITS: anchor_bits_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{
		limit_target:   {pow_w3_q, pow_w2_q, pow_w1_q, pow_w0_q},
		half_life:      half_life_q,
		target_spacing: spacing_q,
		anchor_time:    anchor_time_q,
		anchor_bits:    anchor_bits_q
	};

	// schedule error and sign-magnitude 9.16 exponent
	asert_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.expo_valid (expo_valid),
		.expo_stall (expo_stall),
		.expo       (expo)
	);

	// shift count, fraction and cubic 2^frac factor
	asert_pow u_pow (
		.clk          (clk),
		.arst_n       (arst_n),
		.expo_valid   (expo_valid),
		.expo_stall   (expo_stall),
		.expo         (expo),
		.factor_valid (factor_valid),
		.factor_stall (factor_stall),
		.factor       (factor)
	);

	// anchor target scaling and clamp
	asert_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.factor_valid (factor_valid),
		.factor_stall (factor_stall),
		.factor       (factor),
		.target_valid (target_valid),
		.target_stall (target_stall),
		.target       (target)
	);

	// compact encoding, last stage is the output register
	asert_cmpct u_cmpct (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_valid (target_valid),
		.target_stall (target_stall),
		.target       (target),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/asert_div.sv -----
`timescale 1ns / 1ps

module asert_div (
	input  logic                clk,
	input  logic                arst_n,
	input  asert_pkg::cfg_t     cfg,
	input  logic                item_valid,
	output logic                item_stall,
	input  asert_pkg::in_item_t item,
	output logic                expo_valid,
	input  logic                expo_stall,
	output asert_pkg::expo_t    expo
);

	localparam int NSTEP = asert_pkg::QBITS;
	localparam int NS    = NSTEP + 4;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] stl;

	logic [30:0] hl;

	logic signed [32:0] diff_s1;
	logic [40:0]        prod_s1;
	logic signed [42:0] err_s2;
	logic               neg_s3;
	logic [41:0]        mag_s3;

	logic             neg_sn [0:NSTEP];
	logic             big_sn [0:NSTEP];
	logic [30:0]      rem_sn [0:NSTEP];
	logic [NSTEP-1:0] w_sn   [0:NSTEP];

	logic [31:0] r2 [0:NSTEP-1];
	logic        ge [0:NSTEP-1];

	assign hl = (cfg.half_life == '0) ? 31'd1 : cfg.half_life;

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			stl[k] = expo_stall & (&(vld_q | NS'((1 << k) - 1)));
		end
	end

	assign item_stall = stl[0];
	assign expo_valid = vld_q[NS-1];
	assign expo       = '{big: big_sn[NSTEP], neg: neg_sn[NSTEP], mag: w_sn[NSTEP]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (!stl[0]) vld_q[0] <= item_valid;
			for (int k = 1; k < NS; k++) begin
				if (!stl[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		for (int j = 0; j < NSTEP; j++) begin
			r2[j] = {rem_sn[j], w_sn[j][NSTEP-1]};
			ge[j] = r2[j] >= {1'b0, hl};
		end
	end

	always_ff @(posedge clk) begin
		if (!stl[0]) begin
			diff_s1 <= $signed({1'b0, item.prev_time}) - $signed({1'b0, cfg.anchor_time});
			prod_s1 <= 41'(cfg.target_spacing) * 41'({1'b0, item.prev_height} + 25'd1);
		end
		if (!stl[1]) begin
			err_s2 <= 43'(diff_s1) - $signed({2'b00, prod_s1});
		end
		if (!stl[2]) begin
			neg_s3 <= err_s2[42];
			mag_s3 <= err_s2[42] ? 42'(-err_s2) : 42'(err_s2);
		end
		if (!stl[3]) begin
			neg_sn[0] <= neg_s3;
			// quotient would need more than QBITS bits
			big_sn[0] <= mag_s3 >= {2'b00, hl, 9'b0};
			rem_sn[0] <= mag_s3[39:9];
			w_sn[0]   <= {mag_s3[8:0], 16'h0000};
		end
		for (int j = 0; j < NSTEP; j++) begin
			if (!stl[4+j]) begin
				neg_sn[j+1] <= neg_sn[j];
				big_sn[j+1] <= big_sn[j];
				rem_sn[j+1] <= ge[j] ? 31'(r2[j] - {1'b0, hl}) : r2[j][30:0];
				w_sn[j+1]   <= {w_sn[j][NSTEP-2:0], ge[j]};
			end
		end
	end

endmodule

// ----- rtl/asert_pow.sv -----
`timescale 1ns / 1ps

module asert_pow (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               expo_valid,
	output logic               expo_stall,
	input  asert_pkg::expo_t   expo,
	output logic               factor_valid,
	input  logic               factor_stall,
	output asert_pkg::factor_t factor
);

	localparam int NS = 5;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] stl;

	logic [25:0] sexp;

	logic signed [9:0] sh_s1, sh_s2, sh_s3, sh_s4, sh_s5;
	logic [1:0]        kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic [15:0]       frac_s1, frac_s2;
	logic [31:0]       f2_s2;
	logic [63:0]       af_s2, af_s3;
	logic [47:0]       f3_s3;
	logic [63:0]       bf2_s3;
	logic [63:0]       cf3_s4, sab_s4;
	logic [63:0]       total;
	logic [16:0]       factor_s5;

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			stl[k] = factor_stall & (&(vld_q | NS'((1 << k) - 1)));
		end
	end

	assign expo_stall   = stl[0];
	assign factor_valid = vld_q[NS-1];
	assign factor       = '{kind: kind_s5, shifts: sh_s5, factor: factor_s5};

	assign sexp  = expo.neg ? 26'(-{1'b0, expo.mag}) : {1'b0, expo.mag};
	assign total = sab_s4 + cf3_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (!stl[0]) vld_q[0] <= expo_valid;
			for (int k = 1; k < NS; k++) begin
				if (!stl[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stl[0]) begin
			// floor split of the signed 10.16 exponent
			sh_s1   <= $signed(sexp[25:16]);
			frac_s1 <= sexp[15:0];
			if (expo.big) begin
				kind_s1 <= expo.neg ? asert_pkg::KIND_ONE : asert_pkg::KIND_LIMIT;
			end else begin
				kind_s1 <= asert_pkg::KIND_COMPUTED;
			end
		end
		if (!stl[1]) begin
			if (kind_s1 != asert_pkg::KIND_COMPUTED) begin
				kind_s2 <= kind_s1;
			end else if (sh_s1 <= asert_pkg::SHIFT_MIN) begin
				kind_s2 <= asert_pkg::KIND_ONE;
			end else if (sh_s1 >= asert_pkg::SHIFT_MAX) begin
				kind_s2 <= asert_pkg::KIND_LIMIT;
			end else begin
				kind_s2 <= asert_pkg::KIND_COMPUTED;
			end
			sh_s2   <= sh_s1;
			frac_s2 <= frac_s1;
			f2_s2   <= 32'(frac_s1) * 32'(frac_s1);
			af_s2   <= 64'(asert_pkg::POLY_A) * 64'(frac_s1);
		end
		if (!stl[2]) begin
			kind_s3 <= kind_s2;
			sh_s3   <= sh_s2;
			f3_s3   <= 48'(f2_s2) * 48'(frac_s2);
			bf2_s3  <= 64'(asert_pkg::POLY_B) * 64'(f2_s2);
			af_s3   <= af_s2;
		end
		if (!stl[3]) begin
			kind_s4 <= kind_s3;
			sh_s4   <= sh_s3;
			cf3_s4  <= 64'(asert_pkg::POLY_C) * 64'(f3_s3);
			sab_s4  <= af_s3 + bf2_s3 + asert_pkg::POLY_ROUND;
		end
		if (!stl[4]) begin
			kind_s5   <= kind_s4;
			sh_s5     <= sh_s4;
			factor_s5 <= asert_pkg::FACTOR_ONE + 17'(total[63:48]);
		end
	end

endmodule

// ----- rtl/asert_scale.sv -----
`timescale 1ns / 1ps

module asert_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  asert_pkg::cfg_t    cfg,
	input  logic               factor_valid,
	output logic               factor_stall,
	input  asert_pkg::factor_t factor,
	output logic               target_valid,
	input  logic               target_stall,
	output asert_pkg::target_t target
);

	localparam int NS = 4;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] stl;

	logic [7:0]   asize;
	logic [22:0]  aword;
	logic [22:0]  mant;
	logic [7:0]   bsh;
	logic [255:0] shifted;
	logic [9:0]   rsh;
	logic [1:0]   kind_c;

	logic [39:0]       val_s1;
	logic signed [9:0] sh_s1, sh_s2;
	logic [1:0]        kind_s1, kind_s2, kind_s3, kind_s4;
	logic [255:0]      pos_s2;
	logic [255:0]      nxt_s3;
	logic [255:0]      value_s4;

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			stl[k] = target_stall & (&(vld_q | NS'((1 << k) - 1)));
		end
	end

	assign factor_stall = stl[0];
	assign target_valid = vld_q[NS-1];
	assign target       = '{kind: kind_s4, value: value_s4};

	assign asize = cfg.anchor_bits[31:24];
	assign aword = cfg.anchor_bits[22:0];
	assign bsh   = asize - 8'd3;

	// anchor mantissa, right-aligned for the short sizes
	always_comb begin
		if (asize <= 8'd3) begin
			mant = aword >> {2'd3 - asize[1:0], 3'b000};
		end else begin
			mant = aword;
		end
	end

	assign rsh = 10'(-sh_s2);

	always_comb begin
		if (!sh_s2[9]) begin
			shifted = pos_s2 << sh_s2[3:0];
		end else begin
			shifted = pos_s2 >> rsh;
		end
	end

	always_comb begin
		if (kind_s3 != asert_pkg::KIND_COMPUTED) begin
			kind_c = kind_s3;
		end else if (nxt_s3 == '0) begin
			kind_c = asert_pkg::KIND_ONE;
		end else if (nxt_s3 > cfg.limit_target) begin
			kind_c = asert_pkg::KIND_LIMIT;
		end else begin
			kind_c = asert_pkg::KIND_COMPUTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (!stl[0]) vld_q[0] <= factor_valid;
			for (int k = 1; k < NS; k++) begin
				if (!stl[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stl[0]) begin
			val_s1  <= 40'(mant) * 40'(factor.factor);
			sh_s1   <= factor.shifts;
			kind_s1 <= factor.kind;
		end
		if (!stl[1]) begin
			// byte shift of the anchor exponent, truncated at 256 bits
			if (asize <= 8'd3) begin
				pos_s2 <= 256'(val_s1);
			end else if (asize < 8'd35) begin
				pos_s2 <= 256'(val_s1) << {bsh[4:0], 3'b000};
			end else begin
				pos_s2 <= '0;
			end
			sh_s2   <= sh_s1;
			kind_s2 <= kind_s1;
		end
		if (!stl[2]) begin
			nxt_s3  <= {16'h0000, shifted[255:16]};
			kind_s3 <= kind_s2;
		end
		if (!stl[3]) begin
			kind_s4 <= kind_c;
			case (kind_c)
				asert_pkg::KIND_ONE:   value_s4 <= asert_pkg::TARGET_ONE;
				asert_pkg::KIND_LIMIT: value_s4 <= cfg.limit_target;
				default:               value_s4 <= nxt_s3;
			endcase
		end
	end

endmodule

// ----- rtl/asert_cmpct.sv -----
`timescale 1ns / 1ps

module asert_cmpct (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               target_valid,
	output logic               target_stall,
	input  asert_pkg::target_t target,
	output logic               result_valid,
	input  logic               result_stall,
	output asert_pkg::result_t result
);

	localparam int NS = 3;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] stl;

	logic [5:0]   sz;
	logic [279:0] ext;
	logic [5:0]   sz_s1, sz_s2;
	logic [255:0] val_s1;
	logic [1:0]   kind_s1, kind_s2, kind_s3;
	logic [23:0]  c_s2;
	logic [31:0]  bits_s3;

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			stl[k] = result_stall & (&(vld_q | NS'((1 << k) - 1)));
		end
	end

	assign target_stall = stl[0];
	assign result_valid = vld_q[NS-1];
	assign result       = '{next_bits: bits_s3, clamp_kind: kind_s3};

	// significant byte count
	always_comb begin
		sz = '0;
		for (int b = 0; b < 32; b++) begin
			if (|target.value[8*b +: 8]) sz = 6'(b + 1);
		end
	end

	assign ext = {val_s1, 24'h000000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (!stl[0]) vld_q[0] <= target_valid;
			for (int k = 1; k < NS; k++) begin
				if (!stl[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stl[0]) begin
			sz_s1   <= sz;
			val_s1  <= target.value;
			kind_s1 <= target.kind;
		end
		if (!stl[1]) begin
			c_s2    <= ext[{sz_s1, 3'b000} +: 24];
			sz_s2   <= sz_s1;
			kind_s2 <= kind_s1;
		end
		if (!stl[2]) begin
			// keep the mantissa clear of the sign bit
			if (c_s2[23]) begin
				bits_s3 <= {8'(sz_s2) + 8'd1, 8'h00, c_s2[23:8]};
			end else begin
				bits_s3 <= {8'(sz_s2), c_s2};
			end
			kind_s3 <= kind_s2;
		end
	end

endmodule
